FILE: hw/rtl/fbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbw_pkg
// Shared types, codes and helpers of the bilinear flow warp.
// ----------------------------------------------------------------------------
package fbw_pkg;

	localparam int DEF_MAX_WIDTH   = 256;
	localparam int DEF_MAX_HEIGHT  = 256;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WARP = 1'b1;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam int NUM_BANKS = 4;

	// per-axis neighbor pair and fraction
	typedef struct packed {
		int         i0;
		int         i1;
		logic [5:0] frac;
	} fbw_axis_t;

	// warp context carried alongside the store reads
	typedef struct packed {
		logic [5:0] fx;
		logic [5:0] fy;
		logic [7:0] dx;
		logic [7:0] dy;
		logic       x0p;
		logic       x1p;
		logic       y0p;
		logic       y1p;
	} fbw_info_t;

	// last valid index for a register value: clamp to [1, max], minus one
	function automatic int fbw_lim(input logic [8:0] value, input int max_size);
		int v;
		v = int'(value);
		if (v < 1) return 0;
		if (v > max_size) return max_size - 1;
		return v - 1;
	endfunction

	// floor of pos + flow in Q.6, neighbors clamped to [0, lim]
	function automatic fbw_axis_t fbw_axis(input logic [7:0] pos,
			input logic signed [15:0] flow, input int lim);
		fbw_axis_t r;
		int s;
		int fl;
		s  = int'(pos) * 64 + int'(flow);
		fl = s >>> 6;
		r.frac = 6'(s);
		r.i0 = (fl < 0) ? 0 : ((fl > lim) ? lim : fl);
		r.i1 = (fl + 1 < 0) ? 0 : ((fl + 1 > lim) ? lim : fl + 1);
		if (fl < 0 || fl >= lim) r.frac = '0;
		return r;
	endfunction

endpackage

FILE: hw/rtl/fbw_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbw_addr
// First stage: neighbor clamp, fractions and bank addresses per transaction.
// ----------------------------------------------------------------------------
module fbw_addr import fbw_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int XW          = $clog2(MAX_WIDTH),
	parameter int YW          = $clog2(MAX_HEIGHT),
	parameter int ADW         = 1
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          op,
	input  logic [7:0]                    pos_x,
	input  logic [7:0]                    pos_y,
	input  logic signed [15:0]            sample_value,
	input  logic signed [15:0]            flow_x,
	input  logic signed [15:0]            flow_y,
	input  logic [XW-1:0]                 wlim,
	input  logic [YW-1:0]                 hlim,
	output logic                          op_s1,
	output logic                          inrange_s1,
	output logic [1:0]                    wbank_s1,
	output logic [ADW-1:0]                waddr_s1,
	output logic signed [SAMPLE_BITS-1:0] wdata_s1,
	output logic [ADW-1:0]                raddr_s1 [NUM_BANKS],
	output fbw_info_t                     info_s1
);

	localparam int HALF_W = (MAX_WIDTH + 1) / 2;

	function automatic logic [ADW-1:0] bank_addr(input logic [XW-1:0] x,
			input logic [YW-1:0] y);
		return ADW'(int'(y >> 1) * HALF_W + int'(x >> 1));
	endfunction

	fbw_axis_t ax, ay;
	logic [XW-1:0] x0, x1, lx;
	logic [YW-1:0] y0, y1, ly;
	logic signed [31:0] sext;
	logic [ADW-1:0] raddr [NUM_BANKS];

	always_comb begin
		ax = fbw_axis(pos_x, flow_x, int'(wlim));
		ay = fbw_axis(pos_y, flow_y, int'(hlim));
		x0 = XW'(ax.i0);
		x1 = XW'(ax.i1);
		y0 = YW'(ay.i0);
		y1 = YW'(ay.i1);
		lx = XW'(int'(pos_x));
		ly = YW'(int'(pos_y));
		sext = 32'(sample_value);
		for (int b = 0; b < NUM_BANKS; b++) begin
			raddr[b] = bank_addr((x0[0] == b[0]) ? x0 : x1, (y0[0] == b[1]) ? y0 : y1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= op;
			inrange_s1 <= (int'(pos_x) < MAX_WIDTH) && (int'(pos_y) < MAX_HEIGHT);
			wbank_s1   <= {ly[0], lx[0]};
			waddr_s1   <= bank_addr(lx, ly);
			wdata_s1   <= sext[SAMPLE_BITS-1:0];
			raddr_s1   <= raddr;
			info_s1    <= '{fx: ax.frac, fy: ay.frac, dx: pos_x, dy: pos_y,
				x0p: x0[0], x1p: x1[0], y0p: y0[0], y1p: y1[0]};
		end
	end

endmodule

FILE: hw/rtl/fbw_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbw_store
// Frame store split in four banks by row and column parity; one read per bank.
// ----------------------------------------------------------------------------
module fbw_store import fbw_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DEPTH       = 2,
	parameter int ADW         = 1
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          wr,
	input  logic [1:0]                    wbank,
	input  logic [ADW-1:0]                waddr,
	input  logic signed [SAMPLE_BITS-1:0] wdata,
	input  logic [ADW-1:0]                raddr [NUM_BANKS],
	input  fbw_info_t                     info_in,
	output logic signed [SAMPLE_BITS-1:0] rdata_s2 [NUM_BANKS],
	output fbw_info_t                     info_s2
);

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (en) begin
				if (wr && wbank == 2'(b)) begin
					mem[waddr] <= wdata;
				end
				rdata_s2[b] <= mem[raddr[b]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s2 <= info_in;
		end
	end

endmodule

FILE: hw/rtl/fbw_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbw_blend
// Bilinear blend: horizontal pass, vertical pass, round and saturate.
// ----------------------------------------------------------------------------
module fbw_blend import fbw_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          en3,
	input  logic                          en4,
	input  logic                          en5,
	input  logic signed [SAMPLE_BITS-1:0] rdata_s2 [NUM_BANKS],
	input  fbw_info_t                     info_s2,
	output logic [15:0]                   value_s5,
	output logic [7:0]                    dx_s5,
	output logic [7:0]                    dy_s5
);

	localparam int TW = SAMPLE_BITS + 8;
	localparam int SW = SAMPLE_BITS + 16;
	localparam int RW = SW - 12;
	localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] LO = -HI - RW'(1);

	logic signed [SAMPLE_BITS-1:0] v00, v10, v01, v11;
	logic signed [8:0] wx0, wx1, wy0, wy1;
	logic signed [TW-1:0] top_s3, bot_s3;
	logic [5:0] fy_s3;
	logic [7:0] dx_s3, dy_s3, dx_s4, dy_s4;
	logic signed [SW-1:0] sum_s4;
	logic signed [RW-1:0] r, sat;
	logic signed [31:0] ext;

	always_comb begin
		v00 = rdata_s2[{info_s2.y0p, info_s2.x0p}];
		v10 = rdata_s2[{info_s2.y0p, info_s2.x1p}];
		v01 = rdata_s2[{info_s2.y1p, info_s2.x0p}];
		v11 = rdata_s2[{info_s2.y1p, info_s2.x1p}];
		wx1 = $signed({3'b000, info_s2.fx});
		wx0 = 9'sd64 - wx1;
		wy1 = $signed({3'b000, fy_s3});
		wy0 = 9'sd64 - wy1;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			top_s3 <= TW'(v00) * TW'(wx0) + TW'(v10) * TW'(wx1);
			bot_s3 <= TW'(v01) * TW'(wx0) + TW'(v11) * TW'(wx1);
			fy_s3  <= info_s2.fy;
			dx_s3  <= info_s2.dx;
			dy_s3  <= info_s2.dy;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sum_s4 <= SW'(top_s3) * SW'(wy0) + SW'(bot_s3) * SW'(wy1) + SW'(2048);
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
		end
	end

	// arithmetic shift floors, so ties round up
	always_comb begin
		r   = RW'(sum_s4 >>> 12);
		sat = (r > HI) ? HI : ((r < LO) ? LO : r);
		ext = 32'(sat);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			value_s5 <= ext[15:0];
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
		end
	end

endmodule

FILE: hw/rtl/flow_bilinear_warp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_bilinear_warp
// Backward warp of one image plane by a per-pixel flow field, bilinear blend.
//
// Channel   Direction  Contents
// s_*       in         tuser opcode; tdata pos_x, pos_y, sample_value, flow_x, flow_y
// m_*       out        tdata warped_value, dest_x, dest_y (one per warp transaction)
// cfg_*     in         cfg_index selects frame_width or frame_height, cfg_data value
//
// One transaction per clock while the output is not stalled, through five register
// stages; a warp result is presented from the fifth stage.
// Four parity banks of the frame store give the four neighbor reads in the same cycle.
// Each stage holds only while it is full and the next one is stalled.
// The frame store is not cleared at reset; read only what was loaded.
// ----------------------------------------------------------------------------
module flow_bilinear_warp import fbw_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // pos_x, pos_y, sample_value, flow_x, flow_y
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // warped_value, dest_x, dest_y
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int DEPTH  = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
	localparam int ADW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [XW-1:0] wlim_q;
	logic [YW-1:0] hlim_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic                          op_s1, inrange_s1;
	logic [1:0]                    wbank_s1;
	logic [ADW-1:0]                waddr_s1;
	logic signed [SAMPLE_BITS-1:0] wdata_s1;
	logic [ADW-1:0]                raddr_s1 [NUM_BANKS];
	fbw_info_t                     info_s1, info_s2;
	logic signed [SAMPLE_BITS-1:0] rdata_s2 [NUM_BANKS];
	logic [15:0]                   value_s5;
	logic [7:0]                    dx_s5, dy_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q <= XW'(fbw_lim(9'd256, MAX_WIDTH));
			hlim_q <= YW'(fbw_lim(9'd256, MAX_HEIGHT));
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  wlim_q <= XW'(fbw_lim(cfg_data, MAX_WIDTH));
				CFG_HEIGHT: hlim_q <= YW'(fbw_lim(cfg_data, MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	assign en5 = !v_s5 || m_tready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	// loads retire at the store write; only warps travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1 && (op_s1 == OP_WARP);
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	fbw_addr #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS),
		.XW(XW), .YW(YW), .ADW(ADW)
	) u_addr (
		.clk(clk), .en(en1), .op(s_tuser),
		.pos_x(s_tdata[7:0]), .pos_y(s_tdata[15:8]),
		.sample_value(s_tdata[31:16]), .flow_x(s_tdata[47:32]), .flow_y(s_tdata[63:48]),
		.wlim(wlim_q), .hlim(hlim_q),
		.op_s1(op_s1), .inrange_s1(inrange_s1), .wbank_s1(wbank_s1),
		.waddr_s1(waddr_s1), .wdata_s1(wdata_s1), .raddr_s1(raddr_s1), .info_s1(info_s1)
	);

	fbw_store #(
		.SAMPLE_BITS(SAMPLE_BITS), .DEPTH(DEPTH), .ADW(ADW)
	) u_store (
		.clk(clk), .en(en2),
		.wr(v_s1 && (op_s1 == OP_LOAD) && inrange_s1),
		.wbank(wbank_s1), .waddr(waddr_s1), .wdata(wdata_s1),
		.raddr(raddr_s1), .info_in(info_s1),
		.rdata_s2(rdata_s2), .info_s2(info_s2)
	);

	fbw_blend #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_blend (
		.clk(clk), .en3(en3), .en4(en4), .en5(en5),
		.rdata_s2(rdata_s2), .info_s2(info_s2),
		.value_s5(value_s5), .dx_s5(dx_s5), .dy_s5(dy_s5)
	);

	assign m_tvalid = v_s5;
	assign m_tdata  = {dy_s5, dx_s5, value_s5};

endmodule
